// ===== src/histeq_pkg.sv =====
package histeq_pkg;

    localparam int BINS     = 256;
    localparam int BIN_BITS = 8;
    localparam int PIX_MAX  = 255;

    typedef enum logic
    {
        OP_COUNT = 1'b0,
        OP_MAP   = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                operation;
        logic [BIN_BITS-1:0] pixel;
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_BUILD,
        ST_MAP_RD,
        ST_MAP_OUT
    } back_state_t;

endpackage

// ===== src/histeq_front.sv =====
module histeq_front
    import histeq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  logic    operation,
    input  logic [7:0] pixel,
    output logic    cmd_valid,
    output cmd_t    cmd,
    input  logic    cmd_take
);

    localparam int DEPTH = 4;

    cmd_t           fifo_reg [DEPTH];
    logic [1:0]     wr_ptr_reg;
    logic [1:0]     rd_ptr_reg;
    logic [2:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == 3'(DEPTH));
    assign cmd_valid = (count_reg != 3'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= '{operation: operation, pixel: pixel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

// ===== src/histeq_div.sv =====
module histeq_div
#(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [7:0]          quot
);

    localparam int STEP_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]  q_reg;
    logic [DEN_BITS:0]    r_reg;
    logic [DEN_BITS-1:0]  d_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_BITS:0]    r_shift;
    logic [DEN_BITS:0]    r_sub;

    assign r_shift = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};
    assign done    = done_reg;
    // saturate to 255
    assign quot    = (q_reg > NUM_BITS'(255)) ? 8'hff : q_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!r_sub[DEN_BITS])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/histeq_back.sv =====
module histeq_back
    import histeq_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_take,
    output logic       res_valid,
    output logic [7:0] res_pixel,
    output logic       res_empty,
    output logic       res_overflow,
    input  logic       res_take
);

    localparam int NUM_BITS = COUNT_BITS + 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] bins_mem [BINS];
    logic [7:0]            map_mem [BINS];
    logic [COUNT_BITS-1:0] bin_rd_reg;
    logic [7:0]            map_rd_reg;

    back_state_t           state_reg, state_next;
    logic [BIN_BITS-1:0]   idx_reg, idx_next;
    logic                  clr_last_reg, clr_last_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] cdf_reg, cdf_next;
    logic                  map_phase_reg, map_phase_next;
    logic                  ovf_reg, ovf_next;
    logic                  busy_reg, busy_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_empty_reg, res_empty_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic [7:0]            res_pixel_reg, res_pixel_next;

    logic                  bin_we;
    logic [BIN_BITS-1:0]   bin_waddr;
    logic [COUNT_BITS-1:0] bin_wdata;
    logic [BIN_BITS-1:0]   bin_raddr;
    logic                  map_we;
    logic [BIN_BITS-1:0]   map_raddr;
    logic                  div_start;
    logic                  div_done;
    logic [7:0]            div_quot;
    logic [COUNT_BITS-1:0] cdf_sum;

    // cdf never exceeds total, so no carry
    assign cdf_sum = cdf_reg + bin_rd_reg;

    histeq_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_BITS'({cdf_sum, 8'd0}) - NUM_BITS'(cdf_sum)),
        .den   (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bins_mem[bin_waddr] <= bin_wdata;
        end
        bin_rd_reg <= bins_mem[bin_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[idx_reg] <= (total_reg == '0) ? 8'd0 : div_quot;
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        clr_last_next  = clr_last_reg;
        total_next     = total_reg;
        cdf_next       = cdf_reg;
        map_phase_next = map_phase_reg;
        ovf_next       = ovf_reg;
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;
        res_pixel_next = res_pixel_reg;
        cmd_take       = 1'b0;
        bin_we         = 1'b0;
        bin_waddr      = idx_reg;
        bin_wdata      = '0;
        bin_raddr      = cmd.pixel;
        map_we         = 1'b0;
        map_raddr      = cmd.pixel;
        div_start      = 1'b0;

        if (res_valid_reg && res_take)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                bin_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == BIN_BITS'(BINS - 1))
                begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.operation == OP_COUNT)
                    begin
                        if (map_phase_reg)
                        begin
                            // new frame: sweep bins clear, then count
                            map_phase_next = 1'b0;
                            total_next     = '0;
                            ovf_next       = 1'b0;
                            idx_next       = '0;
                            state_next     = ST_CLEAR;
                        end
                        else
                        begin
                            state_next = ST_CNT_RD;
                        end
                    end
                    else if (!map_phase_reg)
                    begin
                        idx_next   = '0;
                        cdf_next   = '0;
                        bin_raddr  = '0;
                        clr_last_next = 1'b0;
                        state_next = ST_BUILD;
                    end
                    else if (!res_valid_reg || res_take)
                    begin
                        state_next = ST_MAP_RD;
                    end
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                cmd_take   = 1'b1;
                state_next = ST_IDLE;
                if (total_reg == COUNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    bin_we     = 1'b1;
                    bin_waddr  = cmd.pixel;
                    bin_wdata  = bin_rd_reg + 1'b1;
                    total_next = total_reg + 1'b1;
                end
            end
            ST_BUILD:
            begin
                // busy: divider running for entry idx
                bin_raddr = idx_reg + 1'b1;
                if (!busy_reg)
                begin
                    div_start = 1'b1;
                    busy_next = 1'b1;
                end
                else if (div_done)
                begin
                    map_we    = 1'b1;
                    busy_next = 1'b0;
                    cdf_next  = cdf_sum;
                    idx_next  = idx_reg + 1'b1;
                    if (idx_reg == BIN_BITS'(BINS - 1))
                    begin
                        map_phase_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    bin_raddr = idx_reg;
                end
            end
            ST_MAP_RD:
            begin
                state_next = ST_MAP_OUT;
            end
            ST_MAP_OUT:
            begin
                cmd_take       = 1'b1;
                res_valid_next = 1'b1;
                res_empty_next = (total_reg == '0);
                res_ovf_next   = ovf_reg;
                res_pixel_next = (total_reg == '0) ? 8'd0 : map_rd_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
        res_pixel_reg <= res_pixel_next;
        cdf_reg       <= cdf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            // the sweep after reset has no count item waiting behind it
            clr_last_reg  <= 1'b1;
            total_reg     <= '0;
            map_phase_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= (state_reg == ST_CLEAR && state_next == ST_CNT_RD
                              && clr_last_reg) ? ST_IDLE : state_next;
            idx_reg       <= idx_next;
            clr_last_reg  <= (state_reg == ST_CLEAR) ? clr_last_reg : clr_last_next;
            total_reg     <= total_next;
            map_phase_reg <= map_phase_next;
            ovf_reg       <= ovf_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign res_pixel    = res_pixel_reg;
    assign res_empty    = res_empty_reg;
    assign res_overflow = res_ovf_reg;

endmodule

// ===== src/histogram_equalizer_8bit_core.sv =====
// two-pass 8-bit grayscale histogram equalizer. push count items (operation 0)
// to build a histogram, then map items (operation 1) to get equalized pixels.
// after reset the block sweeps the 256 bins clear before taking items. a count
// item is a bin memory read-modify-write. the first map item of a frame builds
// the table with a (COUNT_BITS+8)-step serial divider per bin; each later map
// item reads the table. a count item after a map pass first clears the bins. a
// 4-deep queue decouples input from the back end, and results sit in an output
// register.
module histogram_equalizer_8bit_core
    import histeq_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       operation,
    input  logic [7:0] pixel,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] mapped_pixel,
    output logic       empty_frame,
    output logic       overflow
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    logic res_valid;

    histeq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .pixel     (pixel),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    histeq_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .res_valid    (res_valid),
        .res_pixel    (mapped_pixel),
        .res_empty    (empty_frame),
        .res_overflow (overflow),
        .res_take     (pop)
    );

    assign empty = !res_valid;

endmodule

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    import histeq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS  = 24;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed
    {
        logic [7:0] mapped_pixel;
        logic       empty_frame;
        logic       overflow;
    } eq_result_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic       operation;
    logic [7:0] pixel;
    logic       empty;
    logic       pop;
    logic [7:0] mapped_pixel;
    logic       empty_frame;
    logic       overflow;

    // equalizer state as the block should hold it
    logic [COUNT_BITS-1:0] hist_bins [BINS];
    logic [COUNT_BITS-1:0] frame_total;
    logic [7:0]            eq_lut [BINS];
    logic                  mapping;
    logic                  frame_overflow;

    eq_result_t pending_pixels [$];

    int gap_pct;
    int stall_pct;
    int errors;
    int cycles;
    int n_sent;
    int n_checked;
    int n_frames;

    histogram_equalizer_8bit_core #(.COUNT_BITS(COUNT_BITS)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .pixel        (pixel),
        .empty        (empty),
        .pop          (pop),
        .mapped_pixel (mapped_pixel),
        .empty_frame  (empty_frame),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void build_lut();
        logic [63:0] cdf;
        logic [63:0] v;
        cdf = 64'd0;
        for (int i = 0; i < BINS; i++)
        begin
            cdf = cdf + 64'(hist_bins[i]);
            if (frame_total == '0)
            begin
                eq_lut[i] = 8'd0;
            end
            else
            begin
                v = (cdf * 64'd255) / 64'(frame_total);
                eq_lut[i] = (v > 64'd255) ? 8'd255 : v[7:0];
            end
        end
    endfunction

    function automatic void equalize_pixel(op_t op, logic [7:0] px);
        eq_result_t r;
        if (op == OP_COUNT)
        begin
            if (mapping)
            begin
                foreach (hist_bins[i]) hist_bins[i] = '0;
                frame_total    = '0;
                frame_overflow = 1'b0;
                mapping        = 1'b0;
            end
            if (frame_total == '1)
            begin
                frame_overflow = 1'b1;
            end
            else
            begin
                hist_bins[px] = hist_bins[px] + 1'b1;
                frame_total   = frame_total + 1'b1;
            end
        end
        else
        begin
            if (!mapping)
            begin
                build_lut();
                mapping = 1'b1;
                n_frames++;
            end
            r.empty_frame  = (frame_total == '0);
            r.mapped_pixel = r.empty_frame ? 8'd0 : eq_lut[px];
            r.overflow     = frame_overflow;
            pending_pixels = {pending_pixels, r};
        end
    endfunction

    task automatic send_pixel(op_t op, logic [7:0] px);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        operation <= op;
        pixel     <= px;
        do
            @(posedge clk);
        while (full);
        equalize_pixel(op, px);
        n_sent++;
    endtask

    // drain what is still queued, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 60; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 60; end
            default: begin gap_pct = 30; stall_pct = 30; end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("result transfer with nothing expected: mapped_pixel %0d",
                           mapped_pixel);
                    errors++;
                end
                else
                begin
                    eq_result_t exp_r;
                    exp_r = pending_pixels.pop_front();
                    n_checked++;
                    if (mapped_pixel !== exp_r.mapped_pixel)
                    begin
                        $error("mapped_pixel: expected %0d, got %0d",
                               exp_r.mapped_pixel, mapped_pixel);
                        errors++;
                    end
                    if (empty_frame !== exp_r.empty_frame)
                    begin
                        $error("empty_frame: expected %0d, got %0d",
                               exp_r.empty_frame, empty_frame);
                        errors++;
                    end
                    if (overflow !== exp_r.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               exp_r.overflow, overflow);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_map_after_reset();
        send_pixel(OP_MAP, 8'd0);
        send_pixel(OP_MAP, 8'd255);
        send_pixel(OP_MAP, 8'hA5);
    endtask

    task automatic test_pixel_extremes();
        send_pixel(OP_COUNT, 8'd0);
        send_pixel(OP_COUNT, 8'd255);
        send_pixel(OP_COUNT, 8'h55);
        send_pixel(OP_COUNT, 8'hAA);
        send_pixel(OP_COUNT, 8'd255);
        send_pixel(OP_MAP, 8'd0);
        send_pixel(OP_MAP, 8'd255);
        send_pixel(OP_MAP, 8'h55);
        send_pixel(OP_MAP, 8'hAA);
        send_pixel(OP_MAP, 8'd1);
    endtask

    task automatic test_new_frame();
        // single-valued frame: every bin at or above it maps to 255
        send_pixel(OP_COUNT, 8'd128);
        send_pixel(OP_COUNT, 8'd128);
        send_pixel(OP_MAP, 8'd127);
        send_pixel(OP_MAP, 8'd128);
        send_pixel(OP_COUNT, 8'd7);
        send_pixel(OP_MAP, 8'd6);
        send_pixel(OP_MAP, 8'd7);
    endtask

    task automatic test_random_frames(int target);
        int mode;
        int n_count;
        int n_map;
        int lo;
        int hi;
        mode = 0;
        while (n_sent < target)
        begin
            set_idling(mode);
            mode++;
            n_count = ($urandom_range(9) == 0) ? $urandom_range(200, 100)
                                               : $urandom_range(40, 1);
            n_map   = $urandom_range(40, 1);
            // narrow pixel spreads give stretched maps, wide ones near identity
            lo = $urandom_range(255);
            hi = $urandom_range(255, lo);
            if ($urandom_range(3) == 0)
            begin
                lo = 0;
                hi = 255;
            end
            repeat (n_count) send_pixel(OP_COUNT, 8'($urandom_range(hi, lo)));
            repeat (n_map)
            begin
                send_pixel(OP_MAP, 8'($urandom_range(255)));
                // occasional stray count breaks a map pass into a new frame
                if ($urandom_range(29) == 0)
                begin
                    send_pixel(OP_COUNT, 8'($urandom_range(255)));
                end
            end
            if (mode % 4 == 0)
            begin
                set_idling(0);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        operation = 1'b0;
        pixel     = 8'd0;
        errors    = 0;
        cycles    = 0;
        n_sent    = 0;
        n_checked = 0;
        n_frames  = 0;
        gap_pct   = 0;
        stall_pct = 0;
        mapping        = 1'b0;
        frame_total    = '0;
        frame_overflow = 1'b0;
        foreach (hist_bins[i]) hist_bins[i] = '0;
        foreach (eq_lut[i]) eq_lut[i] = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_map_after_reset();
        test_pixel_extremes();
        test_new_frame();
        test_random_frames(820);
        drain();

        $display("sent %0d pixels over %0d frames, checked %0d mapped pixels",
                 n_sent, n_frames, n_checked);
        $display("idling phases: none, sender gaps, receiver stalls, both");
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
